[sv/look_at_view_matrix_core_assert.svh]
// Assertion macros shared by the look-at core.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LAVM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look-at core check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LAVM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look-at core check failed");

`endif

[sv/lavm_pkg.sv]
package lavm_pkg;

    localparam int VEC_W    = 32;
    localparam int MAG_W    = 64;
    localparam int MAN_W    = 30;
    localparam int SQR_W    = 2 * MAN_W;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int SQ_REM_W = 33;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int QUO_W    = 31;
    localparam int NUM_W    = MAN_W + 31;
    localparam int DIV_STEPS = QUO_W;
    localparam int SIDE_W   = 6 * VEC_W;

    typedef logic signed [MAG_W-1:0] wide_t;
    typedef logic signed [VEC_W-1:0] word_t;

    localparam word_t ONE_Q30  = 32'sh4000_0000;
    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam wide_t HALF_Q30 = 64'sh0000_0000_2000_0000;

    typedef struct packed {
        logic                    zero;
        logic [2:0]              sgn;
        logic [2:0][MAN_W-1:0]   man;
        logic [SIDE_W-1:0]       side;
    } nrm_carry_t;

    // Signed 32 by 32 product, exact in 64 bits.
    function automatic wide_t mul32(input word_t a, input word_t b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    // Round half up from units of 2^-(30+k) to units of 2^-k.
    function automatic wide_t round30(input wide_t x);
        return (x + HALF_Q30) >>> 30;
    endfunction

    function automatic word_t sat32(input wide_t x);
        if (x > wide_t'(WORD_MAX)) begin
            return WORD_MAX;
        end
        if (x < wide_t'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return word_t'(x);
    endfunction

    function automatic word_t clamp_one(input wide_t x);
        if (x > wide_t'(ONE_Q30)) begin
            return ONE_Q30;
        end
        if (x < -wide_t'(ONE_Q30)) begin
            return -ONE_Q30;
        end
        return word_t'(x);
    endfunction

endpackage

[sv/look_at_view_matrix_core.sv]
// Look-at view matrix core: rotation rows in Q2.30 and translation in Q16.16.
// Throughput is one transaction per cycle; the two normalizers (31-stage square root
// and 31-stage divider each) set the depth, and a stalled output freezes every stage.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
`include "look_at_view_matrix_core_assert.svh"

module look_at_view_matrix_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_hint_x,
    input  logic signed [31:0] up_hint_y,
    input  logic signed [31:0] up_hint_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] side_x,
    output logic signed [31:0] side_y,
    output logic signed [31:0] side_z,
    output logic signed [31:0] true_up_x,
    output logic signed [31:0] true_up_y,
    output logic signed [31:0] true_up_z,
    output logic signed [31:0] back_x,
    output logic signed [31:0] back_y,
    output logic signed [31:0] back_z,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y,
    output logic signed [31:0] shift_z
);
    import lavm_pkg::*;

    // The whole pipeline advances together. It holds only while a finished
    // transaction sits in the output register and the consumer stalls it.
    logic en;

    // Input stage: raw forward vector, with eye and up hint riding alongside.
    logic              p0_vld_reg;
    wide_t             p0_fwd_reg [3];
    logic [SIDE_W-1:0] p0_side_reg;

    // First normalizer: unit forward.
    logic              n1_vld;
    word_t             n1_u [3];
    logic [SIDE_W-1:0] n1_side;
    word_t             n1_eye [3];
    word_t             n1_hint [3];

    // Cross product forward x up hint, split into products and differences.
    logic              c1_vld_reg;
    wide_t             c1_prod_reg [6];
    word_t             c1_fwd_reg [3];
    word_t             c1_eye_reg [3];
    logic              c2_vld_reg;
    wide_t             c2_raw_reg [3];
    logic [SIDE_W-1:0] c2_side_reg;

    // Second normalizer: unit side, with eye and forward riding alongside.
    logic              n2_vld;
    word_t             n2_u [3];
    logic [SIDE_W-1:0] n2_side;
    word_t             n2_eye [3];
    word_t             n2_fwd [3];

    // Recomputed up and the translation dot products.
    logic              u1_vld_reg;
    wide_t             u1_up_prod_reg [6];
    wide_t             u1_se_prod_reg [3];
    wide_t             u1_fe_prod_reg [3];
    word_t             u1_side_reg [3];
    word_t             u1_fwd_reg [3];
    word_t             u1_eye_reg [3];

    logic              u2_vld_reg;
    word_t             u2_up_reg [3];
    word_t             u2_shx_reg;
    word_t             u2_shz_reg;
    word_t             u2_side_reg [3];
    word_t             u2_fwd_reg [3];
    word_t             u2_eye_reg [3];

    logic              u3_vld_reg;
    wide_t             u3_ue_prod_reg [3];
    word_t             u3_up_reg [3];
    word_t             u3_shx_reg;
    word_t             u3_shz_reg;
    word_t             u3_side_reg [3];
    word_t             u3_fwd_reg [3];

    // Output register.
    logic              u4_vld_reg;
    word_t             u4_side_reg [3];
    word_t             u4_up_reg [3];
    word_t             u4_back_reg [3];
    word_t             u4_shx_reg;
    word_t             u4_shy_reg;
    word_t             u4_shz_reg;

    wide_t             up_raw [3];

    assign en       = !(u4_vld_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_eye[i]  = word_t'(n1_side[SIDE_W-1-VEC_W*i -: VEC_W]);
            n1_hint[i] = word_t'(n1_side[SIDE_W-1-VEC_W*(3+i) -: VEC_W]);
            n2_eye[i]  = word_t'(n2_side[SIDE_W-1-VEC_W*i -: VEC_W]);
            n2_fwd[i]  = word_t'(n2_side[SIDE_W-1-VEC_W*(3+i) -: VEC_W]);
        end
        up_raw[0] = u1_up_prod_reg[0] - u1_up_prod_reg[1];
        up_raw[1] = u1_up_prod_reg[2] - u1_up_prod_reg[3];
        up_raw[2] = u1_up_prod_reg[4] - u1_up_prod_reg[5];
    end

    lavm_norm u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p0_vld_reg),
        .in_v     (p0_fwd_reg),
        .in_side  (p0_side_reg),
        .out_vld  (n1_vld),
        .out_u    (n1_u),
        .out_side (n1_side)
    );

    lavm_norm u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c2_vld_reg),
        .in_v     (c2_raw_reg),
        .in_side  (c2_side_reg),
        .out_vld  (n2_vld),
        .out_u    (n2_u),
        .out_side (n2_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            u1_vld_reg <= 1'b0;
            u2_vld_reg <= 1'b0;
            u3_vld_reg <= 1'b0;
            u4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_vld_reg <= in_valid;
            c1_vld_reg <= n1_vld;
            c2_vld_reg <= c1_vld_reg;
            u1_vld_reg <= n2_vld;
            u2_vld_reg <= u1_vld_reg;
            u3_vld_reg <= u2_vld_reg;
            u4_vld_reg <= u3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Forward is target minus eye, exact in 33 bits.
            p0_fwd_reg[0] <= wide_t'(target_x) - wide_t'(eye_x);
            p0_fwd_reg[1] <= wide_t'(target_y) - wide_t'(eye_y);
            p0_fwd_reg[2] <= wide_t'(target_z) - wide_t'(eye_z);
            p0_side_reg   <= {eye_x, eye_y, eye_z, up_hint_x, up_hint_y, up_hint_z};

            // Side = forward x up hint, exact in 64 bits.
            c1_prod_reg[0] <= mul32(n1_u[1], n1_hint[2]);
            c1_prod_reg[1] <= mul32(n1_u[2], n1_hint[1]);
            c1_prod_reg[2] <= mul32(n1_u[2], n1_hint[0]);
            c1_prod_reg[3] <= mul32(n1_u[0], n1_hint[2]);
            c1_prod_reg[4] <= mul32(n1_u[0], n1_hint[1]);
            c1_prod_reg[5] <= mul32(n1_u[1], n1_hint[0]);
            c1_fwd_reg     <= n1_u;
            c1_eye_reg     <= n1_eye;

            c2_raw_reg[0] <= c1_prod_reg[0] - c1_prod_reg[1];
            c2_raw_reg[1] <= c1_prod_reg[2] - c1_prod_reg[3];
            c2_raw_reg[2] <= c1_prod_reg[4] - c1_prod_reg[5];
            c2_side_reg   <= {c1_eye_reg[0], c1_eye_reg[1], c1_eye_reg[2],
                              c1_fwd_reg[0], c1_fwd_reg[1], c1_fwd_reg[2]};

            // Up = side x forward, plus the side and forward dot products with eye.
            u1_up_prod_reg[0] <= mul32(n2_u[1], n2_fwd[2]);
            u1_up_prod_reg[1] <= mul32(n2_u[2], n2_fwd[1]);
            u1_up_prod_reg[2] <= mul32(n2_u[2], n2_fwd[0]);
            u1_up_prod_reg[3] <= mul32(n2_u[0], n2_fwd[2]);
            u1_up_prod_reg[4] <= mul32(n2_u[0], n2_fwd[1]);
            u1_up_prod_reg[5] <= mul32(n2_u[1], n2_fwd[0]);
            for (int i = 0; i < 3; i++)
            begin
                u1_se_prod_reg[i] <= mul32(n2_u[i], n2_eye[i]);
                u1_fe_prod_reg[i] <= mul32(n2_fwd[i], n2_eye[i]);
            end
            u1_side_reg <= n2_u;
            u1_fwd_reg  <= n2_fwd;
            u1_eye_reg  <= n2_eye;

            // Round products from 2^-60 or 2^-46 units down by 30 bits.
            for (int i = 0; i < 3; i++)
            begin
                u2_up_reg[i] <= clamp_one(round30(up_raw[i]));
            end
            u2_shx_reg  <= sat32(round30(-(u1_se_prod_reg[0] + u1_se_prod_reg[1]
                                           + u1_se_prod_reg[2])));
            u2_shz_reg  <= sat32(round30(u1_fe_prod_reg[0] + u1_fe_prod_reg[1]
                                         + u1_fe_prod_reg[2]));
            u2_side_reg <= u1_side_reg;
            u2_fwd_reg  <= u1_fwd_reg;
            u2_eye_reg  <= u1_eye_reg;

            // The up translation needs the rounded up vector, so it trails by a stage.
            for (int i = 0; i < 3; i++)
            begin
                u3_ue_prod_reg[i] <= mul32(u2_up_reg[i], u2_eye_reg[i]);
            end
            u3_up_reg   <= u2_up_reg;
            u3_shx_reg  <= u2_shx_reg;
            u3_shz_reg  <= u2_shz_reg;
            u3_side_reg <= u2_side_reg;
            u3_fwd_reg  <= u2_fwd_reg;

            u4_shy_reg  <= sat32(round30(-(u3_ue_prod_reg[0] + u3_ue_prod_reg[1]
                                           + u3_ue_prod_reg[2])));
            u4_up_reg   <= u3_up_reg;
            u4_side_reg <= u3_side_reg;
            u4_shx_reg  <= u3_shx_reg;
            u4_shz_reg  <= u3_shz_reg;
            for (int i = 0; i < 3; i++)
            begin
                u4_back_reg[i] <= -u3_fwd_reg[i];
            end
        end
    end

    assign out_valid = u4_vld_reg;
    assign side_x    = u4_side_reg[0];
    assign side_y    = u4_side_reg[1];
    assign side_z    = u4_side_reg[2];
    assign true_up_x = u4_up_reg[0];
    assign true_up_y = u4_up_reg[1];
    assign true_up_z = u4_up_reg[2];
    assign back_x    = u4_back_reg[0];
    assign back_y    = u4_back_reg[1];
    assign back_z    = u4_back_reg[2];
    assign shift_x   = u4_shx_reg;
    assign shift_y   = u4_shy_reg;
    assign shift_z   = u4_shz_reg;

    // An accepted transaction must land in the input stage.
    `LAVM_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, p0_vld_reg)

    // The negated forward row is a clamped unit vector component.
    `LAVM_ASSERT_IMP(a_back_range, out_valid, (back_x >= -ONE_Q30) && (back_x <= ONE_Q30) && (back_y >= -ONE_Q30) && (back_y <= ONE_Q30) && (back_z >= -ONE_Q30) && (back_z <= ONE_Q30))

    // A zero side row forces a zero recomputed up and a zero x translation.
    `LAVM_ASSERT_IMP(a_side_zero, out_valid && (side_x == 0) && (side_y == 0) && (side_z == 0), (true_up_x == 0) && (true_up_y == 0) && (true_up_z == 0) && (shift_x == 0))

    // Eye on the target gives a zero forward, hence zero side and zero z translation.
    `LAVM_ASSERT_IMP(a_fwd_zero, out_valid && (back_x == 0) && (back_y == 0) && (back_z == 0), (side_x == 0) && (side_y == 0) && (side_z == 0) && (shift_z == 0))

endmodule

[sv/lavm_norm.sv]
module lavm_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  lavm_pkg::wide_t               in_v [3],
    input  logic [lavm_pkg::SIDE_W-1:0]   in_side,
    output logic                          out_vld,
    output lavm_pkg::word_t               out_u [3],
    output logic [lavm_pkg::SIDE_W-1:0]   out_side
);
    import lavm_pkg::*;

    // Magnitude and sign.
    logic              s0_vld_reg;
    logic [MAG_W-1:0]  s0_mag_reg [3];
    logic [2:0]        s0_sgn_reg;
    logic [SIDE_W-1:0] s0_side_reg;

    // Coarse byte alignment.
    logic              s1_vld_reg;
    logic [MAG_W-1:0]  s1_mag_reg [3];
    logic [2:0]        s1_sgn_reg;
    logic              s1_zero_reg;
    logic [SIDE_W-1:0] s1_side_reg;
    logic [MAG_W-1:0]  s0_or;
    logic [2:0]        coarse;
    logic              coarse_hit;

    // Fine bit alignment.
    logic              s2_vld_reg;
    nrm_carry_t        s2_car_reg;
    logic [MAG_W-1:0]  s1_or;
    logic [2:0]        fine;
    logic              fine_hit;
    logic [MAG_W-1:0]  s1_shifted [3];

    // Squares.
    logic              s3_vld_reg;
    logic [SQR_W-1:0]  s3_sq_reg [3];
    nrm_carry_t        s3_car_reg;

    // Square root, one result bit per stage.
    logic                sq_vld_reg   [SQ_STEPS+1];
    logic                sq_vld_next  [SQ_STEPS+1];
    logic [SUM_W-1:0]    sq_rad_reg   [SQ_STEPS+1];
    logic [SUM_W-1:0]    sq_rad_next  [SQ_STEPS+1];
    logic [SQ_REM_W-1:0] sq_rem_reg   [SQ_STEPS+1];
    logic [SQ_REM_W-1:0] sq_rem_next  [SQ_STEPS+1];
    logic [ROOT_W-1:0]   sq_root_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0]   sq_root_next [SQ_STEPS+1];
    nrm_carry_t          sq_car_reg   [SQ_STEPS+1];
    nrm_carry_t          sq_car_next  [SQ_STEPS+1];
    logic [SQ_REM_W+1:0] sq_tmp;
    logic [SQ_REM_W+1:0] sq_trial;

    // Division, one quotient bit per stage, three lanes.
    logic              dv_vld_reg  [DIV_STEPS+1];
    logic              dv_vld_next [DIV_STEPS+1];
    logic [ROOT_W-1:0] dv_n_reg    [DIV_STEPS+1];
    logic [ROOT_W-1:0] dv_n_next   [DIV_STEPS+1];
    logic [QUO_W-1:0]  dv_rem_reg  [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  dv_rem_next [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  dv_low_reg  [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  dv_low_next [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  dv_q_reg    [DIV_STEPS+1][3];
    logic [QUO_W-1:0]  dv_q_next   [DIV_STEPS+1][3];
    nrm_carry_t        dv_car_reg  [DIV_STEPS+1];
    nrm_carry_t        dv_car_next [DIV_STEPS+1];
    logic [NUM_W-1:0]  dv_num;
    logic [QUO_W:0]    dv_t;

    // Clamp and sign.
    logic              fin_vld_reg;
    word_t             fin_u_reg [3];
    logic [SIDE_W-1:0] fin_side_reg;

    // Quotient of one lane clamped to one, as a non-negative word.
    function automatic word_t fin_val_f(input int i);
        logic [QUO_W-1:0] q;
        q = dv_q_reg[DIV_STEPS][i];
        if (q > QUO_W'(ONE_Q30))
        begin
            q = QUO_W'(ONE_Q30);
        end
        return word_t'({1'b0, q});
    endfunction

    always_comb
    begin
        s0_or      = s0_mag_reg[0] | s0_mag_reg[1] | s0_mag_reg[2];
        coarse     = '0;
        coarse_hit = 1'b0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!coarse_hit && (s0_or[8*k +: 8] != 8'd0))
            begin
                coarse     = 3'(7 - k);
                coarse_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_or    = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        fine     = '0;
        fine_hit = 1'b0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!fine_hit && s1_or[MAG_W-8+k])
            begin
                fine     = 3'(7 - k);
                fine_hit = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_shifted[i] = s1_mag_reg[i] << fine;
        end
    end

    always_comb
    begin
        sq_vld_next[0]  = s3_vld_reg;
        sq_rad_next[0]  = SUM_W'(s3_sq_reg[0]) + SUM_W'(s3_sq_reg[1]) + SUM_W'(s3_sq_reg[2]);
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        sq_car_next[0]  = s3_car_reg;
        sq_tmp          = '0;
        sq_trial        = '0;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_tmp   = {sq_rem_reg[k], sq_rad_reg[k][SUM_W-1-2*k -: 2]};
            sq_trial = (SQ_REM_W+2)'({sq_root_reg[k], 2'b01});
            if (sq_tmp >= sq_trial)
            begin
                sq_rem_next[k+1]  = SQ_REM_W'(sq_tmp - sq_trial);
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k+1]  = SQ_REM_W'(sq_tmp);
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
            sq_vld_next[k+1] = sq_vld_reg[k];
            sq_rad_next[k+1] = sq_rad_reg[k];
            sq_car_next[k+1] = sq_car_reg[k];
        end
    end

    always_comb
    begin
        dv_vld_next[0] = sq_vld_reg[SQ_STEPS];
        dv_n_next[0]   = sq_root_reg[SQ_STEPS];
        dv_car_next[0] = sq_car_reg[SQ_STEPS];
        dv_num         = '0;
        dv_t           = '0;
        for (int i = 0; i < 3; i++)
        begin
            dv_num = NUM_W'({sq_car_reg[SQ_STEPS].man[i], 30'b0})
                   + NUM_W'(sq_root_reg[SQ_STEPS] >> 1);
            dv_rem_next[0][i] = QUO_W'(dv_num[NUM_W-1:QUO_W]);
            dv_low_next[0][i] = dv_num[QUO_W-1:0];
            dv_q_next[0][i]   = '0;
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            dv_vld_next[j+1] = dv_vld_reg[j];
            dv_n_next[j+1]   = dv_n_reg[j];
            dv_car_next[j+1] = dv_car_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                dv_t = {dv_rem_reg[j][i], dv_low_reg[j][i][QUO_W-1-j]};
                dv_low_next[j+1][i] = dv_low_reg[j][i];
                if (dv_t >= {1'b0, dv_n_reg[j]})
                begin
                    dv_rem_next[j+1][i] = QUO_W'(dv_t - {1'b0, dv_n_reg[j]});
                    dv_q_next[j+1][i]   = {dv_q_reg[j][i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j+1][i] = QUO_W'(dv_t);
                    dv_q_next[j+1][i]   = {dv_q_reg[j][i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_vld_reg  <= in_vld;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            fin_vld_reg <= dv_vld_reg[DIV_STEPS];
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_vld_reg[k] <= sq_vld_next[k];
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= dv_vld_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s0_mag_reg[i] <= in_v[i][MAG_W-1] ? $unsigned(-in_v[i]) : $unsigned(in_v[i]);
                s0_sgn_reg[i] <= in_v[i][MAG_W-1];
                s1_mag_reg[i] <= s0_mag_reg[i] << {coarse, 3'b000};
                s2_car_reg.man[i] <= s1_shifted[i][MAG_W-1 -: MAN_W];
                s3_sq_reg[i]  <= s2_car_reg.man[i] * s2_car_reg.man[i];
            end
            s0_side_reg       <= in_side;
            s1_sgn_reg        <= s0_sgn_reg;
            s1_zero_reg       <= (s0_or == '0);
            s1_side_reg       <= s0_side_reg;
            s2_car_reg.zero   <= s1_zero_reg;
            s2_car_reg.sgn    <= s1_sgn_reg;
            s2_car_reg.side   <= s1_side_reg;
            s3_car_reg        <= s2_car_reg;
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_rad_reg[k]  <= sq_rad_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_car_reg[k]  <= sq_car_next[k];
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_n_reg[j]   <= dv_n_next[j];
                dv_car_reg[j] <= dv_car_next[j];
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[j][i] <= dv_rem_next[j][i];
                    dv_low_reg[j][i] <= dv_low_next[j][i];
                    dv_q_reg[j][i]   <= dv_q_next[j][i];
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                fin_u_reg[i] <= dv_car_reg[DIV_STEPS].zero ? '0
                              : (dv_car_reg[DIV_STEPS].sgn[i] ? -fin_val_f(i) : fin_val_f(i));
            end
            fin_side_reg <= dv_car_reg[DIV_STEPS].side;
        end
    end

    assign out_vld  = fin_vld_reg;
    assign out_u    = fin_u_reg;
    assign out_side = fin_side_reg;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the look-at view matrix core.
// Camera setups (eye, target, up hint) go in through the valid/stall input
// channel. A scoreboard object predicts the rotation rows and the translation
// in fixed point for every accepted input transaction. It compares each output
// transaction, field by field, with the oldest prediction it holds.
module testbench;
    import lavm_pkg::*;

    typedef logic [8:0][31:0]  camera_t;   // eye xyz, target xyz, up hint xyz
    typedef logic [11:0][31:0] view_t;     // side, true up, back, shift

    localparam int  HALF_PERIOD = 4;
    localparam int  LATENCY     = 145;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  LONG_HOLD   = 400;
    localparam word_t Q16_ONE   = 32'sh0001_0000;

    // The scoreboard holds the predicted views, oldest first.
    class view_scoreboard;
        view_t views_due[$];
        int    errors;
        int    checked;

        function longint unsigned isqrt(input longint unsigned s);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (s >= res + bitv)
                begin
                    s   = s - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Scales the vector to a common exponent and divides by its length,
        // giving a unit vector in Q2.30. A zero vector stays zero.
        function void normalize(input longint v[3], output longint u[3]);
            longint unsigned m[3];
            longint unsigned top;
            longint unsigned s;
            longint unsigned n;
            longint unsigned q;
            top = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
                if (m[i] > top) top = m[i];
            end
            if (top == 0)
            begin
                u[0] = 0; u[1] = 0; u[2] = 0;
                return;
            end
            while (top < (64'd1 << 29))
            begin
                top = top << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            while (top >= (64'd1 << 30))
            begin
                top = top >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
            n = isqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                q = ((m[i] << 30) + (n >> 1)) / n;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function void cross3(input longint a[3], input longint b[3], output longint r[3]);
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        // Round half up by 2^30; an arithmetic shift is a floor.
        function longint drop30(input longint x);
            return (x + (64'sd1 << 29)) >>> 30;
        endfunction

        function longint saturate(input longint x, input longint lo, input longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        function void note_camera(input camera_t cam);
            longint eye[3], hint[3], fwd_raw[3], fwd[3];
            longint side_raw[3], side[3], up_raw[3], up[3];
            longint dot_s, dot_u, dot_f;
            view_t  v;
            for (int i = 0; i < 3; i++)
            begin
                eye[i]     = longint'($signed(cam[i]));
                hint[i]    = longint'($signed(cam[6 + i]));
                fwd_raw[i] = longint'($signed(cam[3 + i])) - eye[i];
            end
            normalize(fwd_raw, fwd);
            cross3(fwd, hint, side_raw);
            normalize(side_raw, side);
            cross3(side, fwd, up_raw);
            for (int i = 0; i < 3; i++)
                up[i] = saturate(drop30(up_raw[i]), -(64'sd1 << 30), 64'sd1 << 30);
            dot_s = 0; dot_u = 0; dot_f = 0;
            for (int i = 0; i < 3; i++)
            begin
                v[i]     = 32'(side[i]);
                v[3 + i] = 32'(up[i]);
                v[6 + i] = 32'(-fwd[i]);
                dot_s    = dot_s + side[i] * eye[i];
                dot_u    = dot_u + up[i] * eye[i];
                dot_f    = dot_f + fwd[i] * eye[i];
            end
            v[9]  = 32'(saturate(drop30(-dot_s), -64'sd2147483648, 64'sd2147483647));
            v[10] = 32'(saturate(drop30(-dot_u), -64'sd2147483648, 64'sd2147483647));
            v[11] = 32'(saturate(drop30(dot_f), -64'sd2147483648, 64'sd2147483647));
            views_due.push_back(v);
        endfunction

        function void check_view(input view_t got);
            view_t want;
            if (views_due.size() == 0)
            begin
                $display("%0t: output transaction with no prediction waiting", $time);
                errors++;
                return;
            end
            want = views_due.pop_front();
            checked++;
            for (int i = 0; i < 12; i++)
            begin
                if (got[i] !== want[i])
                begin
                    $display("%0t: field %0d expected %0d actual %0d", $time, i,
                             $signed(want[i]), $signed(got[i]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    word_t eye_x, eye_y, eye_z, target_x, target_y, target_z;
    word_t up_hint_x, up_hint_y, up_hint_z;
    word_t side_x, side_y, side_z, true_up_x, true_up_y, true_up_z;
    word_t back_x, back_y, back_z, shift_x, shift_y, shift_z;

    view_scoreboard sb;
    int  cycles;
    bit  tx_gaps;       // the sender idles between transactions
    bit  rx_gaps;       // the receiver stalls between transactions
    bit  long_hold;     // one long receiver hold is requested
    int  sent;

    look_at_view_matrix_core i_dut (.*);

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog: a hung pipeline ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL look_at_view_matrix_core");
            $finish;
        end
    end

    // Offer one camera setup, after a random idle gap when tx_gaps is set, and
    // wait for it to be taken. The payload stays put while the core stalls its input.
    task automatic send_camera(input camera_t cam);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        eye_x     <= cam[0]; eye_y    <= cam[1]; eye_z    <= cam[2];
        target_x  <= cam[3]; target_y <= cam[4]; target_z <= cam[5];
        up_hint_x <= cam[6]; up_hint_y <= cam[7]; up_hint_z <= cam[8];
        do @(posedge clk); while (in_stall);
        sb.note_camera(cam);
        sent++;
    endtask

    function automatic camera_t make_camera(input word_t ex, ey, ez, tx, ty, tz,
                                            hx, hy, hz);
        return {hz, hy, hx, tz, ty, tx, ez, ey, ex};
    endfunction

    function automatic word_t any_word();
        return word_t'($urandom);
    endfunction

    // Coordinates within about +-512 units, the usual scene scale.
    function automatic word_t scene_word();
        return word_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    // Random setups: mostly ordinary scenes, some at full range, and some in
    // the degenerate cases (eye on the target, up hint zero or along forward).
    task automatic send_random_camera();
        camera_t cam;
        int      kind;
        int      k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) cam[i] = (kind < 6) ? scene_word() : any_word();
        if (kind == 7)
        begin
            for (int i = 0; i < 3; i++) cam[3 + i] = cam[i];
        end
        else if (kind == 8)
        begin
            for (int i = 0; i < 3; i++) cam[6 + i] = '0;
        end
        else if (kind == 9)
        begin
            for (int i = 0; i < 9; i++) cam[i] = scene_word() >>> 8;
            k = $urandom_range(1, 4);
            for (int i = 0; i < 3; i++)
                cam[6 + i] = (cam[3 + i] - cam[i]) * ($urandom_range(0, 1) ? k : -k);
        end
        send_camera(cam);
    endtask

    // While rx_gaps is set the receiver draws a random stall before every transaction;
    // on request it holds off for a long stretch so the pipeline fills and backs up.
    initial
    begin
        int wait_cycles;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            wait_cycles = rx_gaps ? $urandom_range(0, 9) : 0;
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_view({shift_z, shift_y, shift_x, back_z, back_y, back_x,
                           true_up_z, true_up_y, true_up_x, side_z, side_y, side_x});
        end
    end

    initial
    begin
        int settle;
        sb        = new();
        sent      = 0;
        tx_gaps   = 1'b0;
        rx_gaps   = 1'b0;
        long_hold = 1'b0;
        rst_n     = 1'b0;
        in_valid  <= 1'b0;
        eye_x     <= '0; eye_y    <= '0; eye_z    <= '0;
        target_x  <= '0; target_y <= '0; target_z <= '0;
        up_hint_x <= '0; up_hint_y <= '0; up_hint_z <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed setups, sent back to back.
        send_camera(make_camera(0, 0, 0, 0, 0, -Q16_ONE, 0, Q16_ONE, 0));
        send_camera(make_camera(0, 0, 5 * Q16_ONE, 0, 0, 0, 0, Q16_ONE, 0));
        send_camera(make_camera(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_camera(make_camera(Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE,
                                Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE, 0, Q16_ONE, 0));
        send_camera(make_camera(0, 0, 0, 0, Q16_ONE, 0, 0, Q16_ONE, 0));
        send_camera(make_camera(0, 0, 0, Q16_ONE, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, 0, 0, Q16_ONE, 0, 0, -7 * Q16_ONE));
        send_camera(make_camera(WORD_MIN, WORD_MIN, WORD_MIN,
                                WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX));
        send_camera(make_camera(WORD_MAX, WORD_MAX, WORD_MAX,
                                WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN));
        send_camera(make_camera(WORD_MAX, WORD_MIN, WORD_MAX,
                                WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, WORD_MIN));
        send_camera(make_camera(WORD_MIN, 0, 0, WORD_MAX, 0, 0, 0, WORD_MAX, 0));
        send_camera(make_camera(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_camera(make_camera(0, 0, 0, 1, 1, 1, -1, 1, -1));
        send_camera(make_camera(-1, -1, -1, -1, -1, -1, 1, 1, 1));
        send_camera(make_camera(WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, WORD_MIN, 0, 0));
        send_camera(make_camera(32'sh0123_4567, 32'sh7654_3210, 32'sh0FED_CBA9,
                                32'sh1357_9BDF, 32'sh0246_8ACE, 32'shFEDC_BA98,
                                WORD_MIN, WORD_MIN, WORD_MIN));

        // The receiver holds off while the sender keeps offering, so the
        // pipeline fills and the core stalls its input.
        long_hold = 1'b1;
        repeat (200) send_random_camera();

        // The sender pauses until every predicted view has been received.
        in_valid <= 1'b0;
        while (sb.views_due.size() != 0) @(posedge clk);
        @(posedge clk);

        // Random idling on both sides, then on each side alone.
        tx_gaps = 1'b1; rx_gaps = 1'b1;
        repeat (300) send_random_camera();
        tx_gaps = 1'b0; rx_gaps = 1'b1;
        repeat (150) send_random_camera();
        tx_gaps = 1'b1; rx_gaps = 1'b0;
        repeat (150) send_random_camera();
        in_valid <= 1'b0;

        settle = 0;
        while (sb.views_due.size() != 0 && settle < 20 * LATENCY)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (2 * LATENCY) @(posedge clk);

        $display("Sent %0d camera setups, checked %0d views with %0d mismatches,",
                 sent, sb.checked, sb.errors);
        $display("including degenerate setups, full-range extremes and a filled pipeline.");
        if (sb.errors == 0 && sb.views_due.size() == 0)
        begin
            $display("PASS look_at_view_matrix_core");
        end
        else
        begin
            $display("FAIL look_at_view_matrix_core");
        end
        $finish;
    end

endmodule
